[rtl/core/dmvs_pkg.sv]
// Shared types, constants and codes of the dual motor vibration sequencer.
package dmvs_pkg;

  // Motor array and pulse sizing
  localparam int MOTOR_COUNT = 2;
  localparam int MOTOR_IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int RIGHT_IDX   = (MOTOR_COUNT > 1) ? 1 : 0;
  localparam int PULSE_BITS  = 24;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int MAG_W      = 8;
  localparam int TICK_W     = 8;
  localparam int PCT_W      = 7;
  localparam int PERIOD_W   = 24;
  localparam int PULSE_OUT_W = 24;

  // Configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 24;
  localparam logic [CFG_INDEX_W-1:0] REG_PWM_PERIOD = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_DRIVE  = 8'd1;
  localparam logic [PERIOD_W-1:0]    PWM_PERIOD_RST = 24'd1000000;
  localparam logic [PCT_W-1:0]       MIN_DRIVE_RST  = 7'd30;

  // Percent scaling; divide by 100 as a multiply by ceil(2^37/100), then a shift.
  // Exact for every dividend below 2^37/28, which covers the 31-bit operand.
  localparam int FULL_PCT    = 100;
  localparam int DIV_W       = PERIOD_W + PCT_W;
  localparam int RECIP_W     = 31;
  localparam int RECIP_SHIFT = 37;
  localparam int PROD_W      = DIV_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_100 = 31'd1374389535;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPLY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic              enable_left;
    logic              enable_right;
    logic [MAG_W-1:0]  magnitude_left;
    logic [MAG_W-1:0]  magnitude_right;
    logic [TICK_W-1:0] on_ticks;
    logic [TICK_W-1:0] gap_ticks;
    logic [TICK_W-1:0] repeat_count;
  } in_item_t;

  typedef struct packed {
    logic [PULSE_OUT_W-1:0] pulse_left;
    logic [PULSE_OUT_W-1:0] pulse_right;
    logic                   busy_left;
    logic                   busy_right;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV_DUTY,
    ST_START_PULSE,
    ST_DIV_PULSE,
    ST_COMMIT,
    ST_EMIT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic take_item;
    logic start_duty;
    logic start_pulse;
    logic div_step;
    logic commit;
    logic advance;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scale;
    logic last_motor;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/core/dmvs_item_if.sv]
// Input item channel: valid/ready handshake carrying one command item.
interface dmvs_item_if;
  import dmvs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/dmvs_result_if.sv]
// Result channel: valid/ready handshake carrying one result item.
interface dmvs_result_if;
  import dmvs_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/dmvs_cfg_if.sv]
// Configuration write channel: valid/ready handshake with register index and data.
interface dmvs_cfg_if;
  import dmvs_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/dmvs_ctrl.sv]
// Sequencing state machine: walks the motors of one item and drives the scaling unit.
module dmvs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dmvs_pkg::dp_status_t  status,
  output dmvs_pkg::ctrl_cmd_t   cmd
);
  import dmvs_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_next    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status.need_scale) begin
          cmd.start_duty = 1'b1;
          state_next     = ST_DIV_DUTY;
        end else begin
          cmd.commit  = 1'b1;
          cmd.advance = 1'b1;
          state_next  = status.last_motor ? ST_EMIT : ST_EVAL;
        end
      end
      ST_DIV_DUTY: begin
        cmd.div_step = 1'b1;
        state_next   = ST_START_PULSE;
      end
      ST_START_PULSE: begin
        cmd.start_pulse = 1'b1;
        state_next      = ST_DIV_PULSE;
      end
      ST_DIV_PULSE: begin
        cmd.div_step = 1'b1;
        state_next   = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit  = 1'b1;
        cmd.advance = 1'b1;
        state_next  = status.last_motor ? ST_EMIT : ST_EVAL;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/dmvs_datapath.sv]
// Motor state, configuration registers, pulse scaling unit and result register.
module dmvs_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  dmvs_pkg::in_item_t                 in_data,
  input  logic                               cfg_we,
  input  logic [dmvs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [dmvs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  dmvs_pkg::ctrl_cmd_t                cmd,
  output dmvs_pkg::dp_status_t               status,
  output logic                               out_valid,
  input  logic                               out_ready,
  output dmvs_pkg::out_item_t                out_data
);
  import dmvs_pkg::*;

  // Configuration
  logic [PERIOD_W-1:0] pwm_period;
  logic [PCT_W-1:0]    min_drive;

  // Held item and motor pointer
  in_item_t               item;
  logic [MOTOR_IDX_W-1:0] idx;

  // Per-motor state
  logic [MOTOR_COUNT-1:0] armed;
  logic [MOTOR_COUNT-1:0] motor_on;
  logic [TICK_W-1:0]      ticks_left     [MOTOR_COUNT];
  logic [TICK_W-1:0]      loops_done     [MOTOR_COUNT];
  logic [PCT_W-1:0]       held_magnitude [MOTOR_COUNT];
  logic [TICK_W-1:0]      held_on_ticks  [MOTOR_COUNT];
  logic [TICK_W-1:0]      held_gap_ticks [MOTOR_COUNT];
  logic [TICK_W-1:0]      held_repeats   [MOTOR_COUNT];
  logic [PULSE_BITS-1:0]  pulse_width    [MOTOR_COUNT];

  // Divide-by-100 unit: one reciprocal multiply per step
  logic [DIV_W-1:0]  dv;
  logic [PROD_W-1:0] recip_prod;

  logic [PCT_W-1:0]  min_clamped;
  logic [PCT_W-1:0]  duty;
  logic [2*PCT_W-1:0] duty_prod;
  logic [DIV_W-1:0]  pulse_prod;
  logic              en_sel;
  logic [MAG_W-1:0]  mag_sel;
  logic [PCT_W-1:0]  mag_clamped;
  logic              tick_expire;

  always_comb begin
    min_clamped = (min_drive > PCT_W'(FULL_PCT)) ? PCT_W'(FULL_PCT) : min_drive;
    duty_prod   = (2*PCT_W)'(held_magnitude[idx]) *
                  (2*PCT_W)'(PCT_W'(FULL_PCT) - min_clamped);
    duty        = min_clamped + dv[PCT_W-1:0];
    pulse_prod  = DIV_W'(pwm_period) * DIV_W'(duty);
    recip_prod  = PROD_W'(dv) * PROD_W'(RECIP_100);

    en_sel  = 1'b0;
    mag_sel = '0;
    if (idx == MOTOR_IDX_W'(0)) begin
      en_sel  = item.enable_left;
      mag_sel = item.magnitude_left;
    end else if ((MOTOR_COUNT > 1) && (idx == MOTOR_IDX_W'(RIGHT_IDX))) begin
      en_sel  = item.enable_right;
      mag_sel = item.magnitude_right;
    end
    mag_clamped = (mag_sel > MAG_W'(FULL_PCT)) ? PCT_W'(FULL_PCT) : mag_sel[PCT_W-1:0];

    tick_expire = armed[idx] && (ticks_left[idx] <= TICK_W'(1));

    status.need_scale = (item.command == CMD_TICK) && tick_expire && !motor_on[idx];
    status.last_motor = (idx == MOTOR_IDX_W'(MOTOR_COUNT - 1));
    status.out_free   = !out_valid || out_ready;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period <= PWM_PERIOD_RST;
      min_drive  <= MIN_DRIVE_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_PWM_PERIOD) begin
        pwm_period <= cfg_data[PERIOD_W-1:0];
      end else if (cfg_index == REG_MIN_DRIVE) begin
        min_drive <= cfg_data[PCT_W-1:0];
      end
    end
  end

  // Item capture and divider
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item <= in_data;
    end
    if (cmd.start_duty) begin
      dv <= DIV_W'(duty_prod);
    end else if (cmd.start_pulse) begin
      dv <= pulse_prod;
    end else if (cmd.div_step) begin
      dv <= DIV_W'(recip_prod[PROD_W-1:RECIP_SHIFT]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.take_item) begin
      idx <= '0;
    end else if (cmd.advance && !status.last_motor) begin
      idx <= idx + MOTOR_IDX_W'(1);
    end
  end

  // Motor sequencer update, one motor per commit
  always_ff @(posedge clk) begin
    if (rst) begin
      armed    <= '0;
      motor_on <= '0;
      for (int m = 0; m < MOTOR_COUNT; m++) begin
        ticks_left[m]  <= '0;
        loops_done[m]  <= '0;
        pulse_width[m] <= '0;
      end
    end else if (cmd.commit) begin
      case (item.command)
        CMD_TICK: begin
          if (tick_expire) begin
            if (!motor_on[idx]) begin
              pulse_width[idx] <= (held_magnitude[idx] == '0) ? '0 : PULSE_BITS'(dv);
              motor_on[idx]    <= 1'b1;
              ticks_left[idx]  <= held_on_ticks[idx];
            end else begin
              pulse_width[idx] <= '0;
              motor_on[idx]    <= 1'b0;
              if (loops_done[idx] == held_repeats[idx]) begin
                armed[idx]      <= 1'b0;
                ticks_left[idx] <= '0;
              end else begin
                loops_done[idx] <= loops_done[idx] + TICK_W'(1);
                ticks_left[idx] <= held_gap_ticks[idx];
              end
            end
          end else if (armed[idx]) begin
            ticks_left[idx] <= ticks_left[idx] - TICK_W'(1);
          end
        end
        CMD_APPLY: begin
          if (en_sel) begin
            loops_done[idx]  <= '0;
            motor_on[idx]    <= 1'b0;
            pulse_width[idx] <= '0;
            armed[idx]       <= (mag_clamped != '0);
            ticks_left[idx]  <= (mag_clamped != '0) ? item.gap_ticks : '0;
          end
        end
        CMD_STOP: begin
          loops_done[idx]  <= '0;
          motor_on[idx]    <= 1'b0;
          armed[idx]       <= 1'b0;
          ticks_left[idx]  <= '0;
          pulse_width[idx] <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Latched sequence settings; only read while armed
  always_ff @(posedge clk) begin
    if (cmd.commit && (item.command == CMD_APPLY) && en_sel) begin
      held_magnitude[idx] <= mag_clamped;
      held_on_ticks[idx]  <= item.on_ticks;
      held_gap_ticks[idx] <= item.gap_ticks;
      held_repeats[idx]   <= item.repeat_count;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.pulse_left  <= PULSE_OUT_W'(pulse_width[0]);
      out_data.busy_left   <= armed[0];
      out_data.pulse_right <= (MOTOR_COUNT > 1) ? PULSE_OUT_W'(pulse_width[RIGHT_IDX]) : '0;
      out_data.busy_right  <= (MOTOR_COUNT > 1) ? armed[RIGHT_IDX] : 1'b0;
    end
  end

endmodule

[rtl/core/dual_motor_vibration_sequencer_unit.sv]
// Top level of the dual motor vibration sequencer: controller, datapath and channel wiring.
module dual_motor_vibration_sequencer_unit (
  input logic        clk,
  input logic        rst,
  dmvs_item_if.sink   item_ch,
  dmvs_result_if.source result_ch,
  dmvs_cfg_if.sink    cfg_ch
);
  // Each input item is a tick, an apply command or a stop command, and
  // yields exactly one result holding both motors' pulse width and busy flag
  // after the item took effect. The result is loaded after the controller has
  // walked every motor, and the next item can be taken once it is loaded.
  // For every motor that turns on in a tick, the turn-on pulse width
  // period*(min + pct*(100-min)/100)/100 runs twice through one shared
  // divide-by-100 unit (a reciprocal multiply), each pass first loading the
  // product and then dividing it. A new item is taken only after the previous
  // one has finished; its result may still sit in the output register waiting
  // for the sink, and the next item then holds its own result back until that
  // register is free. Configuration writes are always accepted (ready stays
  // high) and must only be issued while no item is in flight; the pulse width
  // uses the register values in force when a motor turns on.
  import dmvs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ch.ready = 1'b1;

  dmvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_ch.valid),
    .in_ready (item_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold the configuration, motor state and result register; walk one motor per commit
  dmvs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (item_ch.data),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .out_data  (result_ch.data)
  );

`ifndef SYNTHESIS
  // One item at a time: after a transfer the input side stays closed
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (item_ch.valid && item_ch.ready) |=> !item_ch.ready)
    else $error("input accepted while an item is in flight");

  // Never overwrite a result the sink has not taken
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!result_ch.valid || result_ch.ready))
    else $error("result register overwritten");

  // A motor that is not armed cannot be driving a pulse
  a_idle_left: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid |-> (result_ch.data.busy_left || (result_ch.data.pulse_left == '0)))
    else $error("left pulse nonzero while idle");

  a_idle_right: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid |-> (result_ch.data.busy_right || (result_ch.data.pulse_right == '0)))
    else $error("right pulse nonzero while idle");
`endif

endmodule

[verif/dmvs_tb_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard class for the rumble sequencer: pulse/busy prediction and result checking.
package dmvs_tb_pkg;
  import dmvs_pkg::*;

  localparam int LEFT  = 0;
  localparam int RIGHT = 1;

  class rumble_scoreboard;
    logic [PERIOD_W-1:0]  period;
    logic [PCT_W-1:0]     min_pct;
    bit                   armed [2];
    bit                   running [2];
    bit [TICK_W-1:0]      ticks_to_go [2];
    bit [TICK_W-1:0]      loops [2];
    bit [PCT_W-1:0]       hold_mag [2];
    bit [TICK_W-1:0]      hold_on [2];
    bit [TICK_W-1:0]      hold_gap [2];
    bit [TICK_W-1:0]      hold_rep [2];
    bit [PULSE_OUT_W-1:0] width [2];
    out_item_t            levels_q [$];
    int                   errors;

    function new();
      period  = PWM_PERIOD_RST;
      min_pct = MIN_DRIVE_RST;
      errors  = 0;
      for (int m = 0; m < 2; m++) begin
        halt(m);
        hold_mag[m] = '0;
        hold_on[m]  = '0;
        hold_gap[m] = '0;
        hold_rep[m] = '0;
      end
    endfunction

    // Duty is the floor plus the magnitude's share of the rest, then scaled by the period.
    function bit [PULSE_OUT_W-1:0] drive_width(bit [PCT_W-1:0] mag);
      longint unsigned pct;
      longint unsigned floor_pct;
      longint unsigned duty;
      longint unsigned counts;
      pct = mag;
      floor_pct = (min_pct > FULL_PCT) ? FULL_PCT : min_pct;
      if (pct == 0) return '0;
      duty = floor_pct + pct * (FULL_PCT - floor_pct) / FULL_PCT;
      counts = period;
      counts = counts * duty / FULL_PCT;
      return counts[PULSE_OUT_W-1:0];
    endfunction

    function void halt(int m);
      loops[m]       = '0;
      running[m]     = 1'b0;
      armed[m]       = 1'b0;
      ticks_to_go[m] = '0;
      width[m]       = '0;
    endfunction

    function void start_seq(int m, bit [MAG_W-1:0] mag, in_item_t it);
      halt(m);
      hold_mag[m] = (mag > FULL_PCT) ? PCT_W'(FULL_PCT) : mag[PCT_W-1:0];
      hold_on[m]  = it.on_ticks;
      hold_gap[m] = it.gap_ticks;
      hold_rep[m] = it.repeat_count;
      if (hold_mag[m] != 0) begin
        armed[m]       = 1'b1;
        ticks_to_go[m] = hold_gap[m];
      end
    endfunction

    function void expire(int m);
      if (!running[m]) begin
        width[m]       = drive_width(hold_mag[m]);
        running[m]     = 1'b1;
        ticks_to_go[m] = hold_on[m];
      end else begin
        width[m]   = '0;
        running[m] = 1'b0;
        if (loops[m] == hold_rep[m]) begin
          armed[m]       = 1'b0;
          ticks_to_go[m] = '0;
        end else begin
          loops[m]++;
          ticks_to_go[m] = hold_gap[m];
        end
      end
    endfunction

    function void tick(int m);
      if (!armed[m]) return;
      if (ticks_to_go[m] <= 1) expire(m);
      else ticks_to_go[m]--;
    endfunction

    function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_PWM_PERIOD) period = value[PERIOD_W-1:0];
      else if (idx == REG_MIN_DRIVE) min_pct = value[PCT_W-1:0];
    endfunction

    function void note_item(in_item_t it);
      out_item_t lv;
      case (it.command)
        CMD_TICK: for (int m = 0; m < 2; m++) tick(m);
        CMD_APPLY: begin
          if (it.enable_left) start_seq(LEFT, it.magnitude_left, it);
          if (it.enable_right) start_seq(RIGHT, it.magnitude_right, it);
        end
        CMD_STOP: for (int m = 0; m < 2; m++) halt(m);
        default: ;
      endcase
      lv.pulse_left  = width[LEFT];
      lv.pulse_right = width[RIGHT];
      lv.busy_left   = armed[LEFT];
      lv.busy_right  = armed[RIGHT];
      levels_q.push_back(lv);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (levels_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %0d %0d %0d %0d", $time,
                 got.pulse_left, got.pulse_right, got.busy_left, got.busy_right);
        return;
      end
      want = levels_q.pop_front();
      compare_field("pulse_left", want.pulse_left, got.pulse_left);
      compare_field("pulse_right", want.pulse_right, got.pulse_right);
      compare_field("busy_left", want.busy_left, got.busy_left);
      compare_field("busy_right", want.busy_right, got.busy_right);
    endfunction

    function int pending();
      return levels_q.size();
    endfunction
  endclass

endpackage

[verif/tb_dual_motor_vibration_sequencer_unit.sv]
`timescale 1ns / 1ps
// Testbench for the dual motor vibration sequencer: directed and random traffic, checked per transfer.
module tb_dual_motor_vibration_sequencer_unit;
  import dmvs_pkg::*;
  import dmvs_tb_pkg::*;

  // Command code the block must ignore, and a register index with no register behind it
  localparam logic [CMD_W-1:0]       CMD_NONE   = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 8'd2;
  localparam int RANDOM_PER_PHASE = 250;
  localparam int MAX_BURST        = 17;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   idling = 1'b1;
  int   stall_left = 0;

  rumble_scoreboard levels = new();

  dmvs_item_if   item_ch ();
  dmvs_result_if result_ch ();
  dmvs_cfg_if    cfg_ch ();

  dual_motor_vibration_sequencer_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .item_ch   (item_ch.sink),
    .result_ch (result_ch.source),
    .cfg_ch    (cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: far beyond the slowest legal run, so only a hung block lands here.
  initial begin
    #20_000_000;
    $display("tb_dual_motor_vibration_sequencer_unit: errors");
    $finish;
  end

  // Present one item and hold it until the transfer. Valid is never dropped here
  // on the accepting edge, so back-to-back items keep valid high without a glitch;
  // a random idle burst drops it first instead.
  task automatic send_item(input in_item_t it);
    if (idling && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk); while (!item_ch.ready);
    levels.note_item(it);
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (levels.pending() != 0) @(posedge clk);
  endtask

  // One register transfer; the caller drops valid after its last write.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    levels.write_register(idx, value);
  endtask

  // Write both registers; the upper data bits of the floor write carry noise
  // that the block has to discard.
  task automatic configure(input logic [PERIOD_W-1:0] period,
                           input logic [PCT_W-1:0] floor_pct);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_MIN_DRIVE, {junk[CFG_DATA_W-1:PCT_W], floor_pct});
    write_reg(REG_PWM_PERIOD, period);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic in_item_t make_item(input logic [CMD_W-1:0] cmd,
                                         input logic el, input logic er,
                                         input logic [MAG_W-1:0] ml, input logic [MAG_W-1:0] mr,
                                         input logic [TICK_W-1:0] on, input logic [TICK_W-1:0] gap,
                                         input logic [TICK_W-1:0] rep);
    in_item_t it;
    it.command         = cmd;
    it.enable_left     = el;
    it.enable_right    = er;
    it.magnitude_left  = ml;
    it.magnitude_right = mr;
    it.on_ticks        = on;
    it.gap_ticks       = gap;
    it.repeat_count    = rep;
    return it;
  endfunction

  // Zero, full scale, above full scale (clamped) and the plain range in between.
  function automatic logic [MAG_W-1:0] pick_magnitude();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return MAG_W'(FULL_PCT);
    if (r == 2) return MAG_W'($urandom_range(FULL_PCT + 1, 255));
    return MAG_W'($urandom_range(1, FULL_PCT - 1));
  endfunction

  // Mostly ticks so that armed sequences run through their pulses and loops;
  // applies use short timing most of the time so whole sequences finish.
  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) it.command = CMD_TICK;
    else if (pick < 93) it.command = CMD_APPLY;
    else if (pick < 97) it.command = CMD_STOP;
    else it.command = CMD_NONE;
    it.enable_left     = 1'($urandom_range(0, 1));
    it.enable_right    = 1'($urandom_range(0, 1));
    it.magnitude_left  = pick_magnitude();
    it.magnitude_right = pick_magnitude();
    if ($urandom_range(0, 7) != 0) begin
      it.on_ticks     = TICK_W'($urandom_range(0, 4));
      it.gap_ticks    = TICK_W'($urandom_range(0, 4));
      it.repeat_count = TICK_W'($urandom_range(0, 3));
    end else begin
      it.on_ticks     = TICK_W'($urandom_range(0, 255));
      it.gap_ticks    = TICK_W'($urandom_range(0, 255));
      it.repeat_count = TICK_W'($urandom_range(0, 255));
    end
    return it;
  endfunction

  task automatic run_phase(input int count);
    for (int i = 0; i < count; i++) send_item(random_item());
    drain();
  endtask

  // Result side: check each transfer, then pick the next ready level, with
  // random stall bursts that hold ready low while idling.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_ch.valid && result_ch.ready) levels.check_result(result_ch.data);
      if (idling && stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, MAX_BURST - 1);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    item_ch.valid <= 1'b0;
    item_ch.data  <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= '0;
    cfg_ch.data   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, under the reset register values.
    // Tick with nothing armed, then the unused code with every field at its top.
    send_item(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_NONE, 1, 1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // Zero start delay fires on the next tick; magnitude above range clamps.
    send_item(make_item(CMD_APPLY, 1, 1, 8'hFF, 100, 1, 0, 0));
    repeat (2) send_item(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
    // Smallest magnitude on the left, zero magnitude disarms the right; zero on
    // time and one repeat walk through a full loop.
    send_item(make_item(CMD_APPLY, 1, 1, 1, 0, 0, 2, 1));
    repeat (6) send_item(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
    // Longest timing on the right alone, then a left-only apply with zero magnitude.
    send_item(make_item(CMD_APPLY, 0, 1, 0, 50, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_APPLY, 1, 0, 0, 77, 3, 3, 3));
    send_item(make_item(CMD_STOP, 1, 1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
    // Stop while both motors are mid-pulse.
    send_item(make_item(CMD_APPLY, 1, 1, 101, 37, 2, 1, 0));
    send_item(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_STOP, 0, 0, 0, 0, 0, 0, 0));
    // Apply with neither motor enabled changes nothing.
    send_item(make_item(CMD_APPLY, 0, 0, 60, 60, 1, 1, 1));
    send_item(make_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // Random phases across register settings: widest period with no floor,
    // smallest period with the highest floor below full scale, floors at and above full scale.
    configure(24'hFFFFFF, 7'd0);
    run_phase(RANDOM_PER_PHASE);
    configure(24'd1, 7'd99);
    run_phase(RANDOM_PER_PHASE);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    configure(PERIOD_W'($urandom_range(1, 24'hFFFFFF)), 7'd127);
    run_phase(RANDOM_PER_PHASE);
    configure(PERIOD_W'($urandom_range(1, 24'hFFFFFF)), 7'd100);
    run_phase(RANDOM_PER_PHASE);
    configure(PWM_PERIOD_RST, PCT_W'($urandom_range(0, 99)));
    run_phase(RANDOM_PER_PHASE);
    repeat (2) begin
      configure(PERIOD_W'($urandom_range(1, 24'hFFFFFF)), PCT_W'($urandom_range(0, 127)));
      run_phase(RANDOM_PER_PHASE);
    end

    // Last stretch at full rate on both sides.
    idling = 1'b0;
    configure(PERIOD_W'($urandom_range(1, 24'hFFFFFF)), MIN_DRIVE_RST);
    run_phase(RANDOM_PER_PHASE);

    // Leave room for a stray extra result to show up.
    repeat (50) @(posedge clk);
    if (levels.errors == 0 && levels.pending() == 0) begin
      $display("tb_dual_motor_vibration_sequencer_unit: clean");
    end else begin
      $display("tb_dual_motor_vibration_sequencer_unit: errors");
    end
    $finish;
  end

endmodule

[dual_motor_vibration_sequencer_unit.f]
rtl/core/dmvs_pkg.sv
rtl/core/dmvs_item_if.sv
rtl/core/dmvs_result_if.sv
rtl/core/dmvs_cfg_if.sv
rtl/core/dmvs_ctrl.sv
rtl/core/dmvs_datapath.sv
rtl/core/dual_motor_vibration_sequencer_unit.sv
verif/dmvs_tb_pkg.sv
verif/tb_dual_motor_vibration_sequencer_unit.sv
